### hw/rtl/sdfs_pkg.sv
// Package for the score-sum distance estimator.
// Holds the item and result types, the queue entry type and the fixed constants.
// Used by every module of the block; depends on nothing.
`default_nettype none
package sdfs_pkg;

    localparam int SCORE_W   = 24;
    localparam int LEN_W     = 20;
    localparam int SSUM_W    = SCORE_W + 1;
    localparam int LSUM_W    = LEN_W + 1;
    localparam int ACC_W     = 40;
    localparam int MAG_W     = 38;
    localparam int EXP_W     = 6;
    localparam int FRAC_W    = 24;
    localparam int LOG_W     = EXP_W + FRAC_W;
    localparam int MANT_W    = 31;
    localparam int DIST_W    = 19;
    localparam int PROD_W    = 62;
    localparam int SCALE_W   = 32;

    // Normalization steps plus one squaring round per fraction bit.
    localparam int LOG_LAT   = 2 + FRAC_W;

    localparam int QDEPTH    = 8;
    localparam int QPTR_W    = 3;
    localparam int QCNT_W    = 4;
    localparam int FRONT_STAGES = 3;

    localparam logic [ACC_W-1:0]   SCORE_WEIGHT = 40'd10000;
    localparam logic [ACC_W-1:0]   LEN_WEIGHT   = 40'd5209;
    localparam logic [DIST_W-1:0]  DIST_MAX     = 19'd365485;
    localparam logic [SCALE_W-1:0] LN2_SCALE    = 32'd3605200855;

    typedef struct packed {
        logic signed [SCORE_W-1:0] self_score_x;
        logic signed [SCORE_W-1:0] self_score_y;
        logic signed [SCORE_W-1:0] cross_score_xy;
        logic signed [SCORE_W-1:0] cross_score_yx;
        logic        [LEN_W-1:0]   self_len_x;
        logic        [LEN_W-1:0]   self_len_y;
        logic        [LEN_W-1:0]   cross_len_xy;
        logic        [LEN_W-1:0]   cross_len_yx;
    } item_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              invalid;
    } result_t;

    typedef enum logic [1:0] {
        CLS_LOG     = 2'd0,
        CLS_ZERO    = 2'd1,
        CLS_MAX     = 2'd2,
        CLS_INVALID = 2'd3
    } cls_t;

    typedef struct packed {
        cls_t             cls;
        logic [MAG_W-1:0] num;
        logic [MAG_W-1:0] den;
    } qent_t;

endpackage
`default_nettype wire

### hw/rtl/scoredist_from_score_sums_core.sv
// Top level of the score-sum distance estimator.
// Instantiates sdfs_front, sdfs_queue and sdfs_back; depends on sdfs_pkg.
//
// Usage: drive an item of eight score and length sums on item and raise start;
// the item is taken at a rising edge where start is high and busy is low.
// Each result appears on result for exactly one cycle with done high, and the
// receiver must take it then: it cannot hold results off.
// From the accepting edge to the edge that takes the result, an item passes
// three front stages, the queue memory, the log2 lanes (two normalization steps
// and 24 squaring rounds), and the difference, multiply and rounding stages.
// Throughput is one item per cycle; the back part pops the queue every cycle,
// so busy only rises if the queue could not absorb items already in the front.
// Results leave in accept order. Reset empties the queue and clears all valid
// flags; no item state is kept between items.
`default_nettype none
module scoredist_from_score_sums_core
    import sdfs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire item_t item,
    output logic       busy,
    output logic       done,
    output result_t    result
);

    logic              accept;
    logic              f_valid;
    qent_t             f_ent;
    logic              q_valid;
    qent_t             q_head;
    logic [QCNT_W-1:0] q_count;

    assign accept = start && !busy;
    // Keep room for every item that may still be in the front stages.
    assign busy   = (q_count > QCNT_W'(QDEPTH - FRONT_STAGES - 1));

    sdfs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .in_item  (item),
        .out_valid(f_valid),
        .out_ent  (f_ent)
    );

    sdfs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (f_valid),
        .push_ent (f_ent),
        .pop      (q_valid),
        .not_empty(q_valid),
        .head     (q_head),
        .count    (q_count)
    );

    sdfs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_ent   (q_head),
        .out_valid(done),
        .out_res  (result)
    );

endmodule
`default_nettype wire

### hw/rtl/sdfs_front.sv
// Front part: forms the weighted numerator and denominator and classifies each item.
// Three register stages; depends on sdfs_pkg.
`default_nettype none
module sdfs_front
    import sdfs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire item_t in_item,
    output logic       out_valid,
    output qent_t      out_ent
);

    logic                     v1_reg, v2_reg, v3_reg;
    logic signed [SSUM_W-1:0] xsum_reg, ssum_reg;
    logic        [LSUM_W-1:0] xlen_reg, slen_reg;
    logic signed [ACC_W-1:0]  num_reg, den_reg;
    qent_t                    ent_reg;

    logic signed [ACC_W-1:0]  num_next, den_next;
    logic signed [ACC_W-1:0]  nn, dd;
    logic        [MAG_W+6:0]  hund;
    qent_t                    ent_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        xsum_reg <= SSUM_W'(in_item.cross_score_xy) + SSUM_W'(in_item.cross_score_yx);
        ssum_reg <= SSUM_W'(in_item.self_score_x) + SSUM_W'(in_item.self_score_y);
        xlen_reg <= LSUM_W'(in_item.cross_len_xy) + LSUM_W'(in_item.cross_len_yx);
        slen_reg <= LSUM_W'(in_item.self_len_x) + LSUM_W'(in_item.self_len_y);
        num_reg  <= num_next;
        den_reg  <= den_next;
        ent_reg  <= ent_next;
    end

    always_comb
    begin
        num_next = $signed({{(ACC_W-SSUM_W){xsum_reg[SSUM_W-1]}}, xsum_reg}) * $signed(SCORE_WEIGHT)
                 + $signed({{(ACC_W-LSUM_W){1'b0}}, xlen_reg}) * $signed(LEN_WEIGHT);
        den_next = $signed({{(ACC_W-SSUM_W){ssum_reg[SSUM_W-1]}}, ssum_reg}) * $signed(SCORE_WEIGHT)
                 + $signed({{(ACC_W-LSUM_W){1'b0}}, slen_reg}) * $signed(LEN_WEIGHT);
    end

    // A negative denominator flips both signs so the ratio keeps its sign.
    always_comb
    begin
        nn = den_reg[ACC_W-1] ? -num_reg : num_reg;
        dd = den_reg[ACC_W-1] ? -den_reg : den_reg;
        hund = (MAG_W+7)'(nn[MAG_W-1:0]) * (MAG_W+7)'(100);
        ent_next.num = nn[MAG_W-1:0];
        ent_next.den = dd[MAG_W-1:0];
        if (den_reg == '0)
        begin
            if (num_reg[ACC_W-1])
                ent_next.cls = CLS_MAX;
            else if (num_reg == '0)
                ent_next.cls = CLS_INVALID;
            else
                ent_next.cls = CLS_ZERO;
        end
        else if (nn[ACC_W-1] || nn == '0 || hund <= (MAG_W+7)'(dd[MAG_W-1:0]))
            ent_next.cls = CLS_MAX;
        else if (nn[MAG_W-1:0] >= dd[MAG_W-1:0])
            ent_next.cls = CLS_ZERO;
        else
            ent_next.cls = CLS_LOG;
    end

    assign out_valid = v3_reg;
    assign out_ent   = ent_reg;

endmodule
`default_nettype wire

### hw/rtl/sdfs_queue.sv
// Short queue between the front and back parts.
// Register-based FIFO of qent_t entries; depends on sdfs_pkg.
`default_nettype none
module sdfs_queue
    import sdfs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire qent_t push_ent,
    input  wire logic  pop,
    output logic       not_empty,
    output qent_t      head,
    output logic [QCNT_W-1:0] count
);

    qent_t               mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_reg, rd_reg;
    logic [QCNT_W-1:0]   cnt_reg;
    logic                do_pop;

    assign do_pop = pop && (cnt_reg != '0);

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_ent;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + QPTR_W'(1);
            if (do_pop)
                rd_reg <= rd_reg + QPTR_W'(1);
            if (push && !do_pop)
                cnt_reg <= cnt_reg + QCNT_W'(1);
            else if (!push && do_pop)
                cnt_reg <= cnt_reg - QCNT_W'(1);
        end
    end

    assign not_empty = (cnt_reg != '0);
    assign head      = mem[rd_reg];
    assign count     = cnt_reg;

endmodule
`default_nettype wire

### hw/rtl/sdfs_log2.sv
// Pipelined fixed-point log2 lane: normalize, then one squaring round per stage.
// Result has EXP_W integer and FRAC_W fraction bits; depends on sdfs_pkg.
`default_nettype none
module sdfs_log2
    import sdfs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic [MAG_W-1:0] value,
    output logic      [LOG_W-1:0] log_out
);

    logic [MAG_W-1:0]  v_reg;
    logic [EXP_W-1:0]  e1_reg;
    logic [EXP_W-1:0]  e_next;

    logic [MANT_W-1:0] m_reg    [FRAC_W+1];
    logic [EXP_W-1:0]  e_reg    [FRAC_W+1];
    logic [FRAC_W-1:0] frac_reg [FRAC_W+1];

    logic [MANT_W-1:0] m_next   [FRAC_W];
    logic              bit_next [FRAC_W];
    logic [MAG_W-1:0]  shifted;

    // Position of the leading one; the highest set bit is assigned last and wins.
    always_comb
    begin
        e_next = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (value[i])
                e_next = EXP_W'(i);
        end
    end

    assign shifted = v_reg << (EXP_W'(MAG_W - 1) - e1_reg);

    always_comb
    begin
        logic [2*MANT_W-1:0] sq;
        logic [MANT_W:0]     t;
        for (int s = 0; s < FRAC_W; s++)
        begin
            sq = m_reg[s] * m_reg[s];
            t  = sq[2*MANT_W-1:MANT_W-1];
            bit_next[s] = t[MANT_W];
            m_next[s]   = t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg       <= value;
        e1_reg      <= e_next;
        m_reg[0]    <= shifted[MAG_W-1:MAG_W-MANT_W];
        e_reg[0]    <= e1_reg;
        frac_reg[0] <= '0;
        for (int s = 0; s < FRAC_W; s++)
        begin
            m_reg[s+1]    <= m_next[s];
            e_reg[s+1]    <= e_reg[s];
            frac_reg[s+1] <= {frac_reg[s][FRAC_W-2:0], bit_next[s]};
        end
    end

    assign log_out = {e_reg[FRAC_W], frac_reg[FRAC_W]};

endmodule
`default_nettype wire

### hw/rtl/sdfs_back.sv
// Back part: two log2 lanes, their difference, the scaling multiply and rounding.
// Depends on sdfs_pkg and sdfs_log2.
`default_nettype none
module sdfs_back
    import sdfs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire qent_t in_ent,
    output logic       out_valid,
    output result_t    out_res
);

    logic [LOG_W-1:0]  ld, ln;
    logic              vpipe_reg [LOG_LAT];
    cls_t              cpipe_reg [LOG_LAT];

    logic              vd_reg, vp_reg, vo_reg;
    cls_t              cd_reg, cp_reg;
    logic [LOG_W-1:0]  diff_reg;
    logic [PROD_W-1:0] prod_reg;
    result_t           res_reg, res_next;
    logic [PROD_W:0]   rsum;
    logic [PROD_W-40:0] rval;

    sdfs_log2 u_log_den (.clk(clk), .value(in_ent.den), .log_out(ld));
    sdfs_log2 u_log_num (.clk(clk), .value(in_ent.num), .log_out(ln));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LOG_LAT; i++)
                vpipe_reg[i] <= 1'b0;
            vd_reg <= 1'b0;
            vp_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            vpipe_reg[0] <= in_valid;
            for (int i = 1; i < LOG_LAT; i++)
                vpipe_reg[i] <= vpipe_reg[i-1];
            vd_reg <= vpipe_reg[LOG_LAT-1];
            vp_reg <= vd_reg;
            vo_reg <= vp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cpipe_reg[0] <= in_ent.cls;
        for (int i = 1; i < LOG_LAT; i++)
            cpipe_reg[i] <= cpipe_reg[i-1];
        cd_reg   <= cpipe_reg[LOG_LAT-1];
        diff_reg <= (ld > ln) ? (ld - ln) : '0;
        cp_reg   <= cd_reg;
        prod_reg <= PROD_W'(diff_reg) * PROD_W'(LN2_SCALE);
        res_reg  <= res_next;
    end

    // Round half up, dropping the low 40 bits of the product, down to Q3.16.
    assign rsum = (PROD_W+1)'(prod_reg) + ((PROD_W+1)'(1) << 39);
    assign rval = rsum[PROD_W:40];

    always_comb
    begin
        res_next.invalid = 1'b0;
        case (cp_reg)
            CLS_LOG:
                res_next.distance = (rval > (PROD_W-39)'(DIST_MAX)) ? DIST_MAX
                                                                     : rval[DIST_W-1:0];
            CLS_MAX:
                res_next.distance = DIST_MAX;
            CLS_INVALID:
            begin
                res_next.distance = '0;
                res_next.invalid  = 1'b1;
            end
            default:
                res_next.distance = '0;
        endcase
    end

    assign out_valid = vo_reg;
    assign out_res   = res_reg;

endmodule
`default_nettype wire

### verif/testbench.sv
// Testbench for the score-sum distance estimator core.
// Drives directed and random items of score and length sums, predicts each distance
// in fixed point, and checks results in order; depends on sdfs_pkg and the core.
`timescale 1ns / 1ps
module testbench;
    import sdfs_pkg::*;

    logic    clk;
    logic    rst_n;
    logic    start;
    item_t   item;
    logic    busy;
    logic    done;
    result_t result;

    result_t dist_expected[$];
    int      fail_count;

    scoredist_from_score_sums_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Fixed-point log2 with 24 fraction bits from a normalized Q1.30 mantissa.
    function automatic logic [63:0] log2_q24(logic [63:0] v);
        int unsigned     e;
        logic [63:0]     m;
        logic [63:0]     frac;
        logic [127:0]    sq;
        e = 0;
        frac = '0;
        while (e < 63 && (v >> (e + 1)) != 0)
            e++;
        if (e >= 30)
            m = v >> (e - 30);
        else
            m = v << (30 - e);
        for (int i = 1; i <= 24; i++)
        begin
            sq = m * m;
            m = sq[93:30];
            if (m >= (64'd2 << 30))
            begin
                m = m >> 1;
                frac[24 - i] = 1'b1;
            end
        end
        return (64'(e) << 24) | frac;
    endfunction

    function automatic result_t predict_distance(item_t it);
        longint      num;
        longint      den;
        logic [63:0] ld;
        logic [63:0] ln;
        logic [63:0] diff;
        logic [127:0] prod;
        logic [63:0] dist_val;
        result_t     r;
        num = 10000 * (longint'(it.cross_score_xy) + longint'(it.cross_score_yx))
            + 5209 * (longint'(it.cross_len_xy) + longint'(it.cross_len_yx));
        den = 10000 * (longint'(it.self_score_x) + longint'(it.self_score_y))
            + 5209 * (longint'(it.self_len_x) + longint'(it.self_len_y));
        dist_val = 0;
        r.invalid = 1'b0;
        if (den == 0)
        begin
            if (num < 0)
                dist_val = 64'(DIST_MAX);
            else if (num == 0)
                r.invalid = 1'b1;
        end
        else
        begin
            if (den < 0)
            begin
                den = -den;
                num = -num;
            end
            if (num <= 0 || 100 * num <= den)
                dist_val = 64'(DIST_MAX);
            else if (num < den)
            begin
                ld = log2_q24(64'(den));
                ln = log2_q24(64'(num));
                diff = (ld > ln) ? ld - ln : 64'd0;
                prod = diff * 128'(LN2_SCALE) + (128'd1 << 39);
                dist_val = prod[103:40];
                if (dist_val > 64'(DIST_MAX))
                    dist_val = 64'(DIST_MAX);
            end
        end
        r.distance = dist_val[DIST_W-1:0];
        return r;
    endfunction

    // Start stays high between back-to-back items; pace drops it before a gap.
    task automatic send_item(item_t it);
        item  <= it;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        dist_expected.push_back(predict_distance(it));
    endtask

    // Random gap after an item, in bursts.
    int burst_left;
    task automatic pace();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 30);
            if ($urandom_range(0, 2) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && done)
        begin
            if (dist_expected.size() == 0)
            begin
                $error("result with no item pending: distance %0d", result.distance);
                fail_count++;
            end
            else
            begin
                exp_r = dist_expected.pop_front();
                if (result.distance !== exp_r.distance)
                begin
                    $error("distance: expected %0d, actual %0d",
                           exp_r.distance, result.distance);
                    fail_count++;
                end
                if (result.invalid !== exp_r.invalid)
                begin
                    $error("invalid: expected %0d, actual %0d",
                           exp_r.invalid, result.invalid);
                    fail_count++;
                end
            end
        end
    end

    function automatic item_t make_item(int sx, int sy, int cxy, int cyx,
                                        int lx, int ly, int lxy, int lyx);
        item_t it;
        it.self_score_x   = sx[23:0];
        it.self_score_y   = sy[23:0];
        it.cross_score_xy = cxy[23:0];
        it.cross_score_yx = cyx[23:0];
        it.self_len_x     = lx[19:0];
        it.self_len_y     = ly[19:0];
        it.cross_len_xy   = lxy[19:0];
        it.cross_len_yx   = lyx[19:0];
        return it;
    endfunction

    task automatic test_directed();
        item_t it;
        send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0));               // both zero
        send_item(make_item(0, 0, 5, 0, 0, 0, 0, 0));               // zero den, pos num
        send_item(make_item(0, 0, -5, 0, 0, 0, 0, 0));              // zero den, neg num
        send_item(make_item(1000, 1000, 1000, 1000, 0, 0, 0, 0));   // ratio one
        send_item(make_item(1000, 1000, 1500, 1500, 0, 0, 0, 0));   // ratio above one
        send_item(make_item(1000, 1000, 10, 10, 0, 0, 0, 0));       // ratio exactly 0.01
        send_item(make_item(1000, 1000, 11, 10, 0, 0, 0, 0));       // just above 0.01
        send_item(make_item(1000, 1000, 999, 1000, 0, 0, 0, 0));    // just below one
        send_item(make_item(-1000, -1000, -500, -500, 0, 0, 0, 0)); // negative den
        send_item(make_item(-1000, -1000, 500, 500, 0, 0, 0, 0));   // neg den, pos num
        send_item(make_item(1000, 1000, -500, 0, 0, 0, 0, 0));      // negative num
        send_item(make_item(5209, 0, 0, 0, 0, 0, 0, 0) );           // pos den, zero num
        send_item(make_item(-5209, 0, 0, 0, 10000, 0, 0, 0));       // zero from cancel
        send_item(make_item(8388607, 8388607, 8388607, 8388607,
                            1048575, 1048575, 1048575, 1048575));
        send_item(make_item(-8388608, -8388608, -8388608, -8388608, 0, 0, 0, 0));
        send_item(make_item(0, 0, 0, 0, 1048575, 1048575, 1048575, 0));
        send_item(make_item(8388607, 8388607, 0, 0, 0, 0, 1048575, 1048575));
        send_item(make_item(-8388608, 8388607, 1, 0, 0, 0, 0, 0));
        send_item(make_item(1, 0, 0, 0, 0, 0, 1, 0));
        for (int i = 0; i < 4; i++)
        begin
            it = make_item(3000, 3000, 3000 >> i, 3000 >> i, 100, 100, 50, 50);
            send_item(it);
        end
    endtask

    function automatic int rand_score(int span);
        int v;
        if ($urandom_range(0, 9) == 0)
            v = $urandom();
        else
            v = int'($urandom_range(0, 2 * span)) - span;
        return v;
    endfunction

    task automatic test_random();
        item_t it;
        int    span;
        int    lspan;
        for (int n = 0; n < 1950; n++)
        begin
            span  = (n % 3 == 0) ? 8388607 : int'($urandom_range(1, 200000));
            lspan = (n % 4 == 0) ? 1048575 : int'($urandom_range(0, 50000));
            it.self_score_x   = 24'(rand_score(span));
            it.self_score_y   = 24'(rand_score(span));
            it.self_len_x     = 20'($urandom_range(0, lspan));
            it.self_len_y     = 20'($urandom_range(0, lspan));
            case ($urandom_range(0, 5))
                0, 1, 2:
                begin
                    // Cross sums a random fraction of the self sums: aimed at the log region.
                    it.cross_score_xy = 24'(int'(longint'(it.self_score_x)
                                         * longint'($urandom_range(1, 100)) / 100));
                    it.cross_score_yx = 24'(int'(longint'(it.self_score_y)
                                         * longint'($urandom_range(1, 100)) / 100));
                    it.cross_len_xy   = 20'(it.self_len_x * $urandom_range(1, 100) / 100);
                    it.cross_len_yx   = 20'(it.self_len_y * $urandom_range(1, 100) / 100);
                end
                3:
                begin
                    it.self_score_y   = -it.self_score_x;
                    it.self_len_x     = '0;
                    it.self_len_y     = '0;
                    it.cross_score_xy = 24'(rand_score(3));
                    it.cross_score_yx = '0;
                    it.cross_len_xy   = 20'($urandom_range(0, 1));
                    it.cross_len_yx   = '0;
                end
                default:
                begin
                    it.cross_score_xy = 24'(rand_score(span));
                    it.cross_score_yx = 24'(rand_score(span));
                    it.cross_len_xy   = 20'($urandom_range(0, lspan));
                    it.cross_len_yx   = 20'($urandom());
                end
            endcase
            send_item(it);
            pace();
        end
    endtask

    initial
    begin
        fail_count = 0;
        burst_left = 0;
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        start <= 1'b0;
        while (dist_expected.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("PASS scoredist_from_score_sums_core");
        else
            $display("FAIL scoredist_from_score_sums_core");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL scoredist_from_score_sums_core");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/sdfs_pkg.sv
hw/rtl/sdfs_front.sv
hw/rtl/sdfs_queue.sv
hw/rtl/sdfs_log2.sv
hw/rtl/sdfs_back.sv
hw/rtl/scoredist_from_score_sums_core.sv
verif/testbench.sv
